### src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge of clk outside reset.
`define SDMD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define SDMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sdmd_pkg.sv
// Package with the types, constants and helper functions of the motion detector.
`default_nettype none

package sdmd_pkg;

	// Number of pixel entries in the background stores; must be a power of two.
	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int PIX_W        = 8;
	localparam int AMP_W        = 4;
	localparam int PROD_W       = PIX_W + AMP_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	// Reset values of the configuration registers.
	localparam logic [AMP_W-1:0] AMP_RESET     = 4'd3;
	localparam logic [PIX_W-1:0] VAR_MIN_RESET = 8'd1;
	localparam logic [PIX_W-1:0] VAR_MAX_RESET = 8'd254;
	localparam logic [PIX_W-1:0] PIX_MAX       = 8'hFF;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PIX_W-1:0]  pix_t;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMPLIFICATION = 2'd0,
		CFG_VAR_MIN       = 2'd1,
		CFG_VAR_MAX       = 2'd2
	} cfg_idx_e_t;

	// Input word: one pixel with its frame address.
	typedef struct packed {
		logic [7:0]  pixel;
		logic [15:0] pixel_addr;
		logic        init_frame;
	} in_t;

	// Output word: motion flag and absolute difference.
	typedef struct packed {
		logic       motion;
		logic [7:0] abs_diff;
	} out_t;

	// Configuration register set.
	typedef struct packed {
		logic [AMP_W-1:0] amplification;
		pix_t             var_min;
		pix_t             var_max;
	} cfg_t;

	// Moves a value one step toward its target, or leaves it when equal.
	function automatic pix_t step_toward(input pix_t cur, input pix_t target);
		pix_t res;
		if (cur < target) begin
			res = cur + 8'd1;
		end else if (cur > target) begin
			res = cur - 8'd1;
		end else begin
			res = cur;
		end
		return res;
	endfunction

	// Reduces a frame address to a store index (modulo the power-of-two depth).
	function automatic addr_t to_index(input logic [15:0] a);
		logic [31:0] ext;
		ext = 32'(a);
		return ext[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/sdmd_var_stage.sv
// Variance update stage: step toward the scaled difference, clamp, motion compare.
`default_nettype none

module sdmd_var_stage import sdmd_pkg::*; (
	input  cfg_t cfg,
	input  logic init,
	input  pix_t var_old,
	input  pix_t prod_sat,
	input  pix_t abs_diff,
	output pix_t var_new,
	output logic motion
);

	pix_t stepped;
	pix_t upper;

	// Step the variance, then limit to var_max and raise to var_min (var_min wins); on init, load var_min.
	always_comb begin
		stepped = step_toward(var_old, prod_sat);
		upper   = (stepped > cfg.var_max) ? cfg.var_max : stepped;
		if (init) begin
			var_new = cfg.var_min;
		end else begin
			var_new = (upper < cfg.var_min) ? cfg.var_min : upper;
		end
		motion = !init && (abs_diff > var_new);
	end

endmodule

`default_nettype wire

### src/sigma_delta_motion_detect_top.sv
// Top level of the per-pixel sigma-delta motion detector.
`default_nettype none

// The block takes one pixel word per clock while in_stall is low and returns one result
// word per pixel, in order. A word accepted at the input passes through stage 1 (store
// read and mean update), stage 2 (scaled difference), stage 3 (variance update and store
// write), then the output register.
// Mean and variance for all pixels live in one store of FRAME_PIXELS 16-bit entries with
// one write and one read port; results of pixels still in flight are forwarded, so the
// same address may come in consecutive cycles. The store is not cleared: each address
// must see a word with init_frame set before it is used. An output stall holds the whole
// pipeline, so in_stall is high exactly while a result waits on a stalled output.
module sigma_delta_motion_detect_top import sdmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int WB_DEPTH = 3;

	cfg_t cfg_q;

	// Background store: mean in the upper byte, variance in the lower byte.
	logic [2*PIX_W-1:0] store_mem [FRAME_PIXELS];

	logic adv;

	logic               valid_s1;
	pix_t               pixel_s1;
	addr_t              addr_s1;
	logic               init_s1;
	logic [2*PIX_W-1:0] mem_rd_s1;
	pix_t               mean_old_s1;
	pix_t               mean_new_s1;
	pix_t               diff_s1;

	logic               valid_s2;
	addr_t              addr_s2;
	logic               init_s2;
	pix_t               mean_s2;
	pix_t               diff_s2;
	pix_t               var_old_s2;
	logic [PROD_W-1:0]  prod_s2;
	pix_t               prod_sat_s2;

	logic               valid_s3;
	addr_t              addr_s3;
	logic               init_s3;
	pix_t               mean_s3;
	pix_t               diff_s3;
	pix_t               var_old_s3;
	pix_t               prod_s3;
	pix_t               var_fwd_s3;
	pix_t               var_new_s3;
	logic               motion_s3;

	// History of the last three store writes, newest at index 0.
	logic               wb_valid_q [WB_DEPTH];
	addr_t              wb_addr_q  [WB_DEPTH];
	pix_t               wb_mean_q  [WB_DEPTH];
	pix_t               wb_var_q   [WB_DEPTH];

	logic               out_valid_q;
	out_t               out_data_q;

	// The whole pipeline moves unless a finished word waits on a stalled output.
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplification <= AMP_RESET;
			cfg_q.var_min       <= VAR_MIN_RESET;
			cfg_q.var_max       <= VAR_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AMPLIFICATION: cfg_q.amplification <= cfg_wdata[AMP_W-1:0];
				CFG_VAR_MIN:       cfg_q.var_min       <= cfg_wdata[PIX_W-1:0];
				CFG_VAR_MAX:       cfg_q.var_max       <= cfg_wdata[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Store write from stage 3 and registered read for the word entering stage 1.
	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			store_mem[addr_s3] <= {mean_s3, var_new_s3};
		end
		if (adv) begin
			mem_rd_s1 <= store_mem[to_index(in_data.pixel_addr)];
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WB_DEPTH; i++) begin
				wb_valid_q[i] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1      <= in_valid;
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			out_valid_q   <= valid_s3;
			wb_valid_q[0] <= valid_s3;
			for (int i = 1; i < WB_DEPTH; i++) begin
				wb_valid_q[i] <= wb_valid_q[i-1];
			end
		end
	end

	// Stage 1: forward the newest mean of the same address, step it (or load the pixel on init), take the difference.
	always_comb begin
		mean_old_s1 = mem_rd_s1[2*PIX_W-1:PIX_W];
		if (wb_valid_q[0] && wb_addr_q[0] == addr_s1) begin
			mean_old_s1 = wb_mean_q[0];
		end
		if (valid_s3 && addr_s3 == addr_s1) begin
			mean_old_s1 = mean_s3;
		end
		if (valid_s2 && addr_s2 == addr_s1) begin
			mean_old_s1 = mean_s2;
		end
		mean_new_s1 = init_s1 ? pixel_s1 : step_toward(mean_old_s1, pixel_s1);
		diff_s1     = (mean_new_s1 > pixel_s1) ? (mean_new_s1 - pixel_s1)
		                                       : (pixel_s1 - mean_new_s1);
	end

	// Stage 2: scale the difference and saturate.
	assign prod_s2     = PROD_W'(cfg_q.amplification) * PROD_W'(diff_s2);
	assign prod_sat_s2 = (prod_s2 > PROD_W'(PIX_MAX)) ? PIX_MAX : prod_s2[PIX_W-1:0];

	// Stage 3: forward the newest variance from writes the store read missed.
	always_comb begin
		var_fwd_s3 = var_old_s3;
		for (int i = WB_DEPTH - 1; i >= 0; i--) begin
			if (wb_valid_q[i] && wb_addr_q[i] == addr_s3) begin
				var_fwd_s3 = wb_var_q[i];
			end
		end
	end

	sdmd_var_stage u_var_stage (
		.cfg      (cfg_q),
		.init     (init_s3),
		.var_old  (var_fwd_s3),
		.prod_sat (prod_s3),
		.abs_diff (diff_s3),
		.var_new  (var_new_s3),
		.motion   (motion_s3)
	);

	// Payload registers of the pipeline, the write history and the output.
	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_s1   <= in_data.pixel;
			addr_s1    <= to_index(in_data.pixel_addr);
			init_s1    <= in_data.init_frame;

			addr_s2    <= addr_s1;
			init_s2    <= init_s1;
			mean_s2    <= mean_new_s1;
			diff_s2    <= diff_s1;
			var_old_s2 <= mem_rd_s1[PIX_W-1:0];

			addr_s3    <= addr_s2;
			init_s3    <= init_s2;
			mean_s3    <= mean_s2;
			diff_s3    <= diff_s2;
			var_old_s3 <= var_old_s2;
			prod_s3    <= prod_sat_s2;

			wb_addr_q[0] <= addr_s3;
			wb_mean_q[0] <= mean_s3;
			wb_var_q[0]  <= var_new_s3;
			for (int i = 1; i < WB_DEPTH; i++) begin
				wb_addr_q[i] <= wb_addr_q[i-1];
				wb_mean_q[i] <= wb_mean_q[i-1];
				wb_var_q[i]  <= wb_var_q[i-1];
			end

			out_data_q.motion   <= motion_s3;
			out_data_q.abs_diff <= diff_s3;
		end
	end

endmodule

`default_nettype wire

### src/sdmd_checker.sv
// Port-level checker of the motion detector and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module sdmd_checker import sdmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// A stalled result word stays offered.
	`SDMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")

	// A stalled result word keeps its payload.
	`SDMD_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled word changed")

	// The input is held back only while a result waits on a stalled output.
	`SDMD_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "needless input stall")

	// Motion means the difference exceeded a variance, so it cannot be zero.
	`SDMD_ASSERT(a_motion_diff, !out_valid || !out_data.motion || |out_data.abs_diff, "motion at zero")

endmodule

bind sigma_delta_motion_detect_top sdmd_checker u_sdmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
